/* rtl/iopr_pkg.sv */
package iopr_pkg;

    localparam int RANGE_ENTRIES_DEF = 8;

    localparam int PORT_W   = 16;
    localparam int LAST_W   = PORT_W + 1;
    localparam int IDX_W    = 3;
    localparam int SIZE_W   = 2;
    localparam int DIR_W    = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK            = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_REQUEST   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_PERMITTED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_UNALIGNED     = 2'd3;

    // item kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_CHECK = 1'b1;

    // access sizes
    localparam logic [SIZE_W-1:0] SIZE_BYTE = 2'd0;
    localparam logic [SIZE_W-1:0] SIZE_WORD = 2'd1;
    localparam logic [SIZE_W-1:0] SIZE_LONG = 2'd2;
    localparam logic [SIZE_W-1:0] SIZE_BAD  = 2'd3;

    // directions
    localparam logic [DIR_W-1:0] DIR_IN  = 2'd0;
    localparam logic [DIR_W-1:0] DIR_OUT = 2'd1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_ENABLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_COUNT  = 1'd1;

    // transaction token walking the cell chain
    typedef struct packed {
        logic              valid;
        logic              search;     // range search required
        logic              bad;        // bad request
        logic              misaligned;
        logic              found;
        logic [IDX_W-1:0]  match;
        logic [PORT_W-1:0] port;
        logic [LAST_W-1:0] last;       // last port touched, no wrap
    } t_tok;

endpackage

/* rtl/iopr_cell.sv */
module iopr_cell
    import iopr_pkg::*;
#(
    parameter int CELL_IDX = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_wr_en,
    input  logic [IDX_W-1:0]   i_wr_index,
    input  logic [PORT_W-1:0]  i_wr_base,
    input  logic [PORT_W-1:0]  i_wr_limit,
    input  logic [COUNT_W-1:0] i_count,
    input  t_tok               i_tok,
    output t_tok               o_tok
);

    logic [PORT_W-1:0] r_base;
    logic [PORT_W-1:0] r_limit;
    t_tok              r_tok;
    t_tok              n_tok;
    logic              in_use;
    logic              hit;

    // entry storage, undefined until loaded
    always_ff @(posedge i_clk) begin
        if (i_wr_en && (int'(i_wr_index) == CELL_IDX)) begin
            r_base  <= i_wr_base;
            r_limit <= i_wr_limit;
        end
    end

    assign in_use = CELL_IDX < int'(i_count);
    assign hit    = in_use && (i_tok.port >= r_base) && (i_tok.last <= {1'b0, r_limit});

    always_comb begin
        n_tok = i_tok;
        if (i_tok.valid && i_tok.search && !i_tok.found && hit) begin
            n_tok.found = 1'b1;
            n_tok.match = IDX_W'(CELL_IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else if (i_en) begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

/* rtl/io_port_range_permission_check.sv */
// Result: a token passes every cell register, then enters the output register.
// Flow: one transaction at a time; a token walks the cell chain one cell per cycle
//   while the chain is not held, and the next enters once it has left the last cell.
// Reset (synchronous, active low): clears configuration, busy, token valid bits and
//   output valid. Range entries are not cleared and are undefined until loaded.
module io_port_range_permission_check
    import iopr_pkg::*;
#(
    parameter int RANGE_ENTRIES = RANGE_ENTRIES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_kind,
    input  logic [IDX_W-1:0]      i_entry_index,
    input  logic [PORT_W-1:0]     i_new_base,
    input  logic [PORT_W-1:0]     i_new_limit,
    input  logic [PORT_W-1:0]     i_port_address,
    input  logic [SIZE_W-1:0]     i_access_size,
    input  logic [DIR_W-1:0]      i_direction,
    // output channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [STATUS_W-1:0]   o_status,
    output logic [IDX_W-1:0]      o_matched_index
);

    // configuration registers
    logic               r_check_enable;
    logic [COUNT_W-1:0] r_range_count;

    // control
    logic               r_busy;       // a transaction is inside the chain
    logic               accept;
    logic               chain_en;
    logic               tail_xfer;

    // output register
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [IDX_W-1:0]    r_match;
    logic [STATUS_W-1:0] n_status;
    logic [IDX_W-1:0]    n_match;

    // token chain: tok[0] enters cell 0, tok[RANGE_ENTRIES] leaves the last cell
    t_tok               tok [RANGE_ENTRIES+1];
    t_tok               tail;
    logic [LAST_W-1:0]  last_port;
    logic               bad_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_enable <= 1'b0;
            r_range_count  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CHECK_ENABLE: r_check_enable <= i_cfg_data[0];
                CFG_RANGE_COUNT:  r_range_count  <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // One transaction at a time through the chain. The output register
    // keeps the input side free while a result waits on a stalled sink.
    assign o_in_stall = r_busy;
    assign accept     = i_in_valid && !r_busy;

    // Chain holds only when a finished token cannot move into the output register.
    assign tail      = tok[RANGE_ENTRIES];
    assign chain_en  = !(tail.valid && r_out_valid && i_out_stall);
    assign tail_xfer = tail.valid && chain_en;

    // Request decode at entry: validity, last port and alignment.
    assign bad_req = (i_direction != DIR_IN && i_direction != DIR_OUT) ||
                     (i_access_size == SIZE_BAD);

    always_comb begin
        case (i_access_size)
            SIZE_WORD: last_port = {1'b0, i_port_address} + LAST_W'(1);
            SIZE_LONG: last_port = {1'b0, i_port_address} + LAST_W'(3);
            default:   last_port = {1'b0, i_port_address};
        endcase
    end

    always_comb begin
        tok[0].valid      = accept;
        tok[0].bad        = (i_kind == KIND_CHECK) && bad_req;
        tok[0].search     = (i_kind == KIND_CHECK) && !bad_req && r_check_enable;
        tok[0].misaligned = (i_kind == KIND_CHECK) &&
                            (((i_access_size == SIZE_WORD) && i_port_address[0]) ||
                             ((i_access_size == SIZE_LONG) && (i_port_address[1:0] != 2'd0)));
        tok[0].found      = 1'b0;
        tok[0].match      = '0;
        tok[0].port       = i_port_address;
        tok[0].last       = last_port;
    end

    // Chain of range cells. A load is broadcast and taken by the addressed
    // cell at accept; its token rides the chain with nothing to search.
    for (genvar g = 0; g < RANGE_ENTRIES; g++) begin : g_cell
        iopr_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_en       (chain_en),
            .i_wr_en    (accept && (i_kind == KIND_LOAD)),
            .i_wr_index (i_entry_index),
            .i_wr_base  (i_new_base),
            .i_wr_limit (i_new_limit),
            .i_count    (r_range_count),
            .i_tok      (tok[g]),
            .o_tok      (tok[g+1])
        );
    end

    // Final status: bad request, then range miss, then alignment.
    always_comb begin
        n_status = ST_OK;
        n_match  = '0;
        if (tail.bad) begin
            n_status = ST_BAD_REQUEST;
        end else if (tail.search && !tail.found) begin
            n_status = ST_NOT_PERMITTED;
        end else if (tail.misaligned) begin
            n_status = ST_UNALIGNED;
        end else if (tail.search) begin
            n_match = tail.match;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
            end else if (tail_xfer) begin
                r_busy <= 1'b0;
            end
            if (tail_xfer) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (tail_xfer) begin
            r_status <= n_status;
            r_match  <= n_match;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_matched_index = r_match;

`ifndef SYNTHESIS
    a_idle_chain_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> !tail.valid)
        else $error("token in chain while idle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_busy)
        else $error("accept did not mark busy");

    a_tail_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tail_xfer |=> (r_out_valid && !r_busy))
        else $error("finished token lost on its way out");

    a_match_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status != ST_OK)) |-> (r_match == '0))
        else $error("matched index set on a failing status");
`endif

endmodule
